### rtl/core/sra_pkg.sv
// shared types and constants for the subregion run allocator
// no dependencies
package sra_pkg;

	localparam int BLOCKS      = 32;
	localparam int TABLE_DEPTH = 13;

	localparam logic [31:0] SMALL_BASE = 32'h2000_1000;
	localparam logic [31:0] PAIR_BASE  = 32'h2000_1E00;
	localparam logic [31:0] LARGE_BASE = 32'h2000_2400;

	localparam logic [14:0] SMALL_LIMIT = 15'd512;
	localparam logic [14:0] PAIR_SIZE   = 15'd1536;
	localparam logic [15:0] LARGE_ROUND = 16'd1023;
	localparam logic [5:0]  MAX_RUN     = 6'd23;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_ROOM    = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

	localparam logic [1:0] MAP_IDLE    = 2'd0;
	localparam logic [1:0] MAP_RESTART = 2'd1;
	localparam logic [1:0] MAP_SCAN    = 2'd2;
	localparam logic [1:0] MAP_WRITE   = 2'd3;

	localparam logic [1:0] TBL_IDLE    = 2'd0;
	localparam logic [1:0] TBL_WRITE   = 2'd1;
	localparam logic [1:0] TBL_RELEASE = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [14:0] size_bytes;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted_address;
		logic [4:0]  first_block;
		logic [4:0]  block_count;
	} rsp_t;

	typedef struct packed {
		logic [1:0] op;
		logic [4:0] idx;
		logic [5:0] need;
		logic       set;
	} map_cmd_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [4:0]  slot;
		logic [31:0] address;
		logic [4:0]  first;
		logic [4:0]  count;
	} tbl_cmd_t;

	typedef struct packed {
		logic        used;
		logic [31:0] address;
		logic [4:0]  first;
		logic [4:0]  count;
	} tbl_view_t;

endpackage

### rtl/core/sra_block_map.sv
// subregion busy map with the shared run counter and compare unit
// depends on sra_pkg
module sra_block_map import sra_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  map_cmd_t cmd,
	output logic     busy,
	output logic     run_hit
);

	logic [BLOCKS-1:0] busy_q;
	logic [5:0]        run_q;

	assign busy    = busy_q[cmd.idx];
	assign run_hit = !busy && ((run_q + 6'd1) == cmd.need);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			run_q  <= '0;
		end else begin
			unique case (cmd.op)
				MAP_RESTART: run_q <= '0;
				MAP_SCAN: run_q <= busy ? 6'd0 : run_q + 6'd1;
				MAP_WRITE: busy_q[cmd.idx] <= cmd.set;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == MAP_WRITE |=> busy_q[$past(cmd.idx)] == $past(cmd.set))
		else $error("busy bit not updated");
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == MAP_RESTART |=> run_q == 6'd0)
		else $error("run counter not cleared");
	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= MAX_RUN)
		else $error("run longer than the large class");
`endif

endmodule

### rtl/core/sra_entry_table.sv
// grant table: address, first subregion and count per entry
// depends on sra_pkg
module sra_entry_table import sra_pkg::*; #(
	parameter int ENTRIES = TABLE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  tbl_cmd_t   cmd,
	input  logic [4:0] rd_idx,
	output tbl_view_t  view
);

	localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [31:0] addr_q  [ENTRIES];
	logic [4:0]  first_q [ENTRIES];
	logic [4:0]  count_q [ENTRIES];
	logic [SW-1:0] rd;
	logic [SW-1:0] wr;

	assign rd = rd_idx[SW-1:0];
	assign wr = cmd.slot[SW-1:0];

	assign view.used    = count_q[rd] != 5'd0;
	assign view.address = addr_q[rd];
	assign view.first   = first_q[rd];
	assign view.count   = count_q[rd];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			unique case (cmd.op)
				TBL_WRITE: count_q[wr] <= cmd.count;
				TBL_RELEASE: count_q[wr] <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == TBL_WRITE) begin
			addr_q[wr]  <= cmd.address;
			first_q[wr] <= cmd.first;
		end
	end

`ifndef SYNTHESIS
	a_write_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == TBL_WRITE |-> cmd.count != 5'd0)
		else $error("grant written with zero count");
	a_write_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == TBL_WRITE |=> count_q[$past(wr)] != 5'd0)
		else $error("written entry not in use");
	a_release_unused: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == TBL_RELEASE |=> count_q[$past(wr)] == 5'd0)
		else $error("released entry still in use");
`endif

endmodule

### rtl/core/subregion_run_allocator_unit.sv
// subregion run allocator: sequencer, request and result registers
// depends on sra_pkg, sra_block_map, sra_entry_table
//
// channel | fields                                            | handshake
// req     | mode, size_bytes, address                         | req_valid / req_stall
// rsp     | status, granted_address, first_block, block_count | rsp_valid / rsp_stall
//
// allocate: capture, table scan (up to TABLE_ENTRIES), subregion scan (up to 23)
// + a mark step per granted subregion + the done state
// free: capture, table scan (up to TABLE_ENTRIES), mark per freed subregion, done
// one transaction at a time, set by the single shared scan index and run counter
// reset frees every subregion and marks every table entry unused
// a stalled result holds in the output register; a new request is taken meanwhile
module subregion_run_allocator_unit import sra_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TSCAN = 3'd1;
	localparam logic [2:0] S_BSCAN = 3'd2;
	localparam logic [2:0] S_FSCAN = 3'd3;
	localparam logic [2:0] S_MARK  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam logic [1:0] CLS_SMALL = 2'd0;
	localparam logic [1:0] CLS_PAIR  = 2'd1;
	localparam logic [1:0] CLS_LARGE = 2'd2;

	localparam logic [4:0] LAST_ENTRY = 5'(TABLE_ENTRIES - 1);

	logic [2:0]  state_q;
	logic        mode_q;
	logic [31:0] address_q;
	logic [1:0]  class_q;
	logic [5:0]  need_q;
	logic [4:0]  idx_q;
	logic [4:0]  first_q;
	logic [4:0]  cnt_q;
	logic [4:0]  slot_q;
	logic [1:0]  status_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	map_cmd_t  map_cmd;
	tbl_cmd_t  tbl_cmd;
	tbl_view_t view;
	logic      busy;
	logic      run_hit;

	logic        accept;
	logic        load_rsp;
	logic [15:0] size_round;
	logic [1:0]  in_class;
	logic [4:0]  lo;
	logic [4:0]  hi;
	logic [4:0]  offset;
	logic [31:0] grant_addr;
	logic [4:0]  run_first;
	logic        mark_last;
	rsp_t        rsp_d;

	sra_block_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (map_cmd),
		.busy    (busy),
		.run_hit (run_hit)
	);

	sra_entry_table #(.ENTRIES(TABLE_ENTRIES)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tbl_cmd),
		.rd_idx (idx_q),
		.view   (view)
	);

	assign accept    = req_valid && !req_stall;
	assign req_stall = state_q != S_IDLE;
	assign load_rsp  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign size_round = {1'b0, req.size_bytes} + LARGE_ROUND;

	always_comb begin
		if (req.size_bytes <= SMALL_LIMIT) begin
			in_class = CLS_SMALL;
		end else if (req.size_bytes == PAIR_SIZE) begin
			in_class = CLS_PAIR;
		end else begin
			in_class = CLS_LARGE;
		end
	end

	always_comb begin
		unique case (class_q)
			CLS_SMALL: begin
				lo = 5'd0;
				hi = 5'd6;
			end
			CLS_PAIR: begin
				lo = 5'd7;
				hi = 5'd8;
			end
			default: begin
				lo = 5'd9;
				hi = 5'd31;
			end
		endcase
	end

	assign offset = first_q - lo;

	always_comb begin
		unique case (class_q)
			CLS_SMALL: grant_addr = SMALL_BASE + ({27'd0, offset} << 9);
			CLS_PAIR: grant_addr = PAIR_BASE + ({27'd0, offset} << 9);
			default: grant_addr = LARGE_BASE + ({27'd0, offset} << 10);
		endcase
	end

	assign run_first = idx_q - need_q[4:0] + 5'd1;
	assign mark_last = ({1'b0, cnt_q} + 6'd1) == need_q;

	always_comb begin
		map_cmd      = '0;
		map_cmd.op   = MAP_IDLE;
		map_cmd.idx  = idx_q;
		map_cmd.need = need_q;
		map_cmd.set  = mode_q == MODE_ALLOC;
		tbl_cmd         = '0;
		tbl_cmd.op      = TBL_IDLE;
		tbl_cmd.slot    = slot_q;
		tbl_cmd.address = grant_addr;
		tbl_cmd.first   = first_q;
		tbl_cmd.count   = need_q[4:0];
		unique case (state_q)
			S_TSCAN: begin
				if (!view.used) begin
					map_cmd.op = MAP_RESTART;
				end
			end
			S_BSCAN: map_cmd.op = MAP_SCAN;
			S_MARK: begin
				map_cmd.op = MAP_WRITE;
				if (mark_last) begin
					tbl_cmd.op = (mode_q == MODE_ALLOC) ? TBL_WRITE : TBL_RELEASE;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp_d        = '0;
		rsp_d.status = status_q;
		if (status_q == ST_OK) begin
			rsp_d.first_block = first_q;
			rsp_d.block_count = need_q[4:0];
			if (mode_q == MODE_ALLOC) begin
				rsp_d.granted_address = grant_addr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (req.mode == MODE_FREE) ? S_FSCAN : S_TSCAN;
					end
				end
				S_TSCAN: begin
					if (!view.used) begin
						state_q <= S_BSCAN;
					end else if (idx_q == LAST_ENTRY) begin
						state_q <= S_DONE;
					end
				end
				S_BSCAN: begin
					if (run_hit) begin
						state_q <= S_MARK;
					end else if (idx_q == hi) begin
						state_q <= S_DONE;
					end
				end
				S_FSCAN: begin
					if (view.used && view.address == address_q) begin
						state_q <= S_MARK;
					end else if (idx_q == LAST_ENTRY) begin
						state_q <= S_DONE;
					end
				end
				S_MARK: begin
					if (mark_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_rsp) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q    <= req.mode;
					address_q <= req.address;
					class_q   <= in_class;
					need_q    <= (in_class == CLS_LARGE) ? size_round[15:10] :
						(in_class == CLS_PAIR) ? 6'd2 : 6'd1;
					idx_q     <= '0;
				end
			end
			S_TSCAN: begin
				if (!view.used) begin
					slot_q <= idx_q;
					idx_q  <= lo;
				end else if (idx_q == LAST_ENTRY) begin
					status_q <= ST_TABLE_FULL;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end
			S_BSCAN: begin
				if (run_hit) begin
					first_q <= run_first;
					idx_q   <= run_first;
					cnt_q   <= '0;
				end else if (idx_q == hi) begin
					status_q <= ST_NO_ROOM;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end
			S_FSCAN: begin
				if (view.used && view.address == address_q) begin
					first_q <= view.first;
					need_q  <= {1'b0, view.count};
					slot_q  <= idx_q;
					idx_q   <= view.first;
					cnt_q   <= '0;
				end else if (idx_q == LAST_ENTRY) begin
					status_q <= ST_NOT_FOUND;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end
			S_MARK: begin
				cnt_q <= cnt_q + 5'd1;
				idx_q <= idx_q + 5'd1;
				if (mark_last) begin
					status_q <= ST_OK;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		load_rsp |=> rsp_valid_q && state_q == S_IDLE)
		else $error("result not delivered from done");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != ST_OK |->
			rsp_q.block_count == 5'd0 && rsp_q.granted_address == 32'd0)
		else $error("failed transaction carries a grant");
	a_mark_need: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MARK |-> need_q != 6'd0 && need_q <= MAX_RUN)
		else $error("run length out of range while marking");
`endif

endmodule

### tb/tb.sv
// self-checking testbench for subregion_run_allocator_unit
// depends on sra_pkg and the allocator rtl; a ledger class predicts each result
// from its own copy of the subregion map and grant table
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sra_pkg::*;

	localparam int SMALL_BYTES = 512;
	localparam int LARGE_BYTES = 1024;
	localparam int RANDOM_ITEMS = 550;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	class run_ledger;
		logic        busy[BLOCKS];
		logic [31:0] ent_addr[TABLE_DEPTH];
		logic [4:0]  ent_first[TABLE_DEPTH];
		logic [4:0]  ent_count[TABLE_DEPTH];
		rsp_t        due_results[$];
		int          errors;

		function new();
			foreach (busy[i]) busy[i] = 1'b0;
			foreach (ent_count[e]) begin
				ent_addr[e] = '0;
				ent_first[e] = '0;
				ent_count[e] = '0;
			end
			errors = 0;
		endfunction

		function void book_request(req_t r);
			rsp_t        res;
			int          slot, lo, hi, need, first, run, bsize;
			logic [31:0] base;
			res = '0;
			slot = -1;
			first = -1;
			run = 0;
			if (r.mode == MODE_ALLOC) begin
				for (int e = 0; e < TABLE_DEPTH; e++)
					if (slot < 0 && ent_count[e] == 0) slot = e;
				if (slot < 0) begin
					res.status = ST_TABLE_FULL;
				end else begin
					if (r.size_bytes <= SMALL_LIMIT) begin
						lo = 0; hi = 6; need = 1; bsize = SMALL_BYTES; base = SMALL_BASE;
					end else if (r.size_bytes == PAIR_SIZE) begin
						lo = 7; hi = 8; need = 2; bsize = SMALL_BYTES; base = PAIR_BASE;
					end else begin
						lo = 9; hi = 31; bsize = LARGE_BYTES; base = LARGE_BASE;
						need = (int'(r.size_bytes) + LARGE_BYTES - 1) / LARGE_BYTES;
					end
					for (int i = lo; i <= hi; i++) begin
						if (first < 0) begin
							if (busy[i]) run = 0;
							else begin
								run++;
								if (run == need) first = i + 1 - need;
							end
						end
					end
					if (first < 0) begin
						res.status = ST_NO_ROOM;
					end else begin
						for (int i = first; i < first + need; i++) busy[i] = 1'b1;
						ent_addr[slot] = base + 32'((first - lo) * bsize);
						ent_first[slot] = 5'(first);
						ent_count[slot] = 5'(need);
						res.status = ST_OK;
						res.granted_address = ent_addr[slot];
						res.first_block = 5'(first);
						res.block_count = 5'(need);
					end
				end
			end else begin
				for (int e = 0; e < TABLE_DEPTH; e++)
					if (slot < 0 && ent_count[e] != 0 && ent_addr[e] == r.address) slot = e;
				if (slot < 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					for (int i = ent_first[slot]; i < ent_first[slot] + ent_count[slot]; i++)
						if (i < BLOCKS) busy[i] = 1'b0;
					res.status = ST_OK;
					res.first_block = ent_first[slot];
					res.block_count = ent_count[slot];
					ent_addr[slot] = '0;
					ent_first[slot] = '0;
					ent_count[slot] = '0;
				end
			end
			due_results.push_back(res);
		endfunction

		function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t %s: expected %h, actual %h", $time, name, want, got);
				errors++;
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void match_result(rsp_t got);
			rsp_t want;
			if (due_results.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = due_results.pop_front();
			void'(field_ok("status", 32'(want.status), 32'(got.status)));
			void'(field_ok("granted_address", want.granted_address, got.granted_address));
			void'(field_ok("first_block", 32'(want.first_block), 32'(got.first_block)));
			void'(field_ok("block_count", 32'(want.block_count), 32'(got.block_count)));
		endfunction

		function void collect_live(output logic [31:0] q[$]);
			q = {};
			foreach (ent_count[e])
				if (ent_count[e] != 0) q.push_back(ent_addr[e]);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	logic      steady;
	int        issued;
	int        cycles;
	run_ledger ledger;

	subregion_run_allocator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk)
		rsp_stall <= steady ? 1'b0 : ($urandom_range(99) < 27);

	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall) ledger.match_result(rsp);

	task automatic send(input req_t item);
		if (!steady && $urandom_range(99) < 27) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		ledger.book_request(item);
		issued++;
	endtask

	task automatic alloc_req(input int size);
		req_t item;
		item.mode = MODE_ALLOC;
		item.size_bytes = 15'(size);
		item.address = $urandom;
		send(item);
	endtask

	task automatic free_req(input logic [31:0] a);
		req_t item;
		item.mode = MODE_FREE;
		item.size_bytes = 15'($urandom);
		item.address = a;
		send(item);
	endtask

	task automatic random_alloc();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) alloc_req($urandom_range(0, SMALL_BYTES));
		else if (pick < 45) alloc_req(int'(PAIR_SIZE));
		else if (pick < 80) alloc_req($urandom_range(SMALL_BYTES + 1, 4 * LARGE_BYTES));
		else if (pick < 90) alloc_req($urandom_range(4 * LARGE_BYTES + 1, 23 * LARGE_BYTES));
		else alloc_req($urandom_range(0, 32767));
	endtask

	task automatic release_all();
		logic [31:0] live[$];
		ledger.collect_live(live);
		foreach (live[i]) free_req(live[i]);
	endtask

	initial begin
		logic [31:0] live[$];
		int          pick;
		ledger = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		steady = 1'b0;
		issued = 0;
		cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// size classes, exact borders and oversize requests
		alloc_req(0);
		alloc_req(512);
		alloc_req(513);
		alloc_req(1536);
		alloc_req(1536);
		alloc_req(23553);
		alloc_req(32767);
		alloc_req(1535);
		alloc_req(1537);
		alloc_req(1024);
		repeat (5) alloc_req(0);
		alloc_req(0);
		// a large run takes the last free table entry, then the table is full
		alloc_req(2048);
		alloc_req(100);
		free_req(32'h1234_5678);
		free_req(LARGE_BASE);
		free_req(LARGE_BASE);
		alloc_req(23552);
		free_req(32'hFFFF_FFFF);
		free_req(32'h0000_0000);
		// whole large region in one run
		release_all();
		alloc_req(23552);

		while (issued < RANDOM_ITEMS + 25) begin
			steady <= (issued >= 300 && issued < 380);
			pick = $urandom_range(99);
			ledger.collect_live(live);
			if (pick < 2) begin
				release_all();
				alloc_req($urandom_range(22 * LARGE_BYTES + 1, 23 * LARGE_BYTES));
				alloc_req(int'(PAIR_SIZE));
			end else if (pick < 50) begin
				random_alloc();
			end else if (pick < 90 && live.size() != 0) begin
				free_req(live[$urandom_range(live.size() - 1)]);
			end else if (pick < 95 && live.size() != 0) begin
				free_req(live[$urandom_range(live.size() - 1)] + SMALL_BYTES);
			end else begin
				free_req($urandom);
			end
		end
		steady <= 1'b0;
		req_valid <= 1'b0;

		while (ledger.due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.errors == 0 && ledger.due_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

### subregion_run_allocator_unit.f
rtl/core/sra_pkg.sv
rtl/core/sra_block_map.sv
rtl/core/sra_entry_table.sv
rtl/core/subregion_run_allocator_unit.sv
tb/tb.sv
